// ===== rtl/slrd_pkg.sv =====
// Shared types, constants and a calendar function for the shelf life block.
package slrd_pkg;

	localparam int YEAR_W     = 14;
	localparam int DAYS_W     = 22;
	localparam int REM_W      = 23;
	localparam int ACC_W      = 23;
	localparam int DELTA_W    = 11;
	localparam int YEAR_LIMIT = 9999;

	// Configuration register indexes
	localparam logic [1:0] REG_TODAY_DAY   = 2'd0;
	localparam logic [1:0] REG_TODAY_MONTH = 2'd1;
	localparam logic [1:0] REG_TODAY_YEAR  = 2'd2;

	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_APR = 4'd4;
	localparam logic [3:0] MONTH_JUN = 4'd6;
	localparam logic [3:0] MONTH_SEP = 4'd9;
	localparam logic [3:0] MONTH_NOV = 4'd11;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	localparam logic [DELTA_W-1:0] DAYS_LEAP_YEAR  = DELTA_W'(366);
	localparam logic [DELTA_W-1:0] DAYS_PLAIN_YEAR = DELTA_W'(365);

	// Control of the shared accumulator
	typedef struct packed {
		logic                      clear;
		logic                      add;
		logic signed [DELTA_W-1:0] delta;
	} acc_ctl_t;

	// Control of the leap-year tracker
	typedef struct packed {
		logic clear;
		logic advance;
	} leap_ctl_t;

	// Length of month m in a year whose leap flag is lp
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
		logic [4:0] len;
		len = 5'd31;
		if (m == MONTH_FEB) begin
			len = lp ? 5'd29 : 5'd28;
		end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP ||
				m == MONTH_NOV) begin
			len = 5'd30;
		end
		return len;
	endfunction

endpackage

// ===== rtl/slrd_leap_track.sv =====
// Leap-year tracker: modulo 4, 100 and 400 counters that follow the year walk.
module slrd_leap_track (
	input  logic                clk,
	input  logic                arst_n,
	input  slrd_pkg::leap_ctl_t ctl,
	output logic                leap
);

	logic [1:0] mod4_q;
	logic [6:0] mod100_q;
	logic [8:0] mod400_q;

	// Advance the counters one year at a time, wrapping at each modulus
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod4_q   <= '0;
			mod100_q <= '0;
			mod400_q <= '0;
		end else if (ctl.clear) begin
			mod4_q   <= '0;
			mod100_q <= '0;
			mod400_q <= '0;
		end else if (ctl.advance) begin
			mod4_q   <= mod4_q + 2'd1;
			mod100_q <= (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
			mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
		end
	end

	// Divisible by 4 and not by 100, or divisible by 400
	assign leap = ((mod4_q == 2'd0) && (mod100_q != 7'd0)) || (mod400_q == 9'd0);

endmodule

// ===== rtl/slrd_accum.sv =====
// Shared day accumulator: one signed adder reused by every walk step.
module slrd_accum (
	input  logic                                clk,
	input  logic                                arst_n,
	input  slrd_pkg::acc_ctl_t                  ctl,
	output logic signed [slrd_pkg::ACC_W-1:0]   total
);

	logic signed [slrd_pkg::ACC_W-1:0] total_q;

	// Clear at the start of a request, add one step's delta otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (ctl.clear) begin
			total_q <= '0;
		end else if (ctl.add) begin
			total_q <= total_q + slrd_pkg::ACC_W'(ctl.delta);
		end
	end

	assign total = total_q;

endmodule

// ===== rtl/shelf_life_remaining_days.sv =====
// Top level: date check, year walk and month correction sequencer.
//
// Usage: write today's date through wr_en / wr_index / wr_data (day, month,
// year at indexes 0, 1, 2) while the block is idle. Pulse start with busy
// low to issue a request carrying arrival_day, arrival_month, arrival_year
// and shelf_life; the fields are captured on that edge. busy stays high
// until the result is ready. The result shows on date_ok, days_elapsed and
// remaining_days for exactly one cycle with done high; the receiver takes it
// on that cycle and cannot stall. busy is low during the done cycle, so a
// new request may be issued there.
// Sequence: a request whose year is out of range or after today's year goes
// straight to the reject state. Otherwise the year walk runs from year 0 up to
// today's year, one year per cycle through the single shared accumulator,
// followed by a check state; a date that fails the month and day check, or
// lies later in today's year, is rejected there. A date that passes goes on
// to 11 month steps, a day step and the emit state. The year walk dominates
// the run time.
// Reset: today's date becomes 2000-01-01 and the sequencer goes idle.
module shelf_life_remaining_days (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [1:0]                           wr_index,
	input  logic [slrd_pkg::YEAR_W-1:0]          wr_data,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [6:0]                           arrival_day,
	input  logic [6:0]                           arrival_month,
	input  logic [slrd_pkg::YEAR_W-1:0]          arrival_year,
	input  logic [15:0]                          shelf_life,
	output logic                                 done,
	output logic                                 date_ok,
	output logic [slrd_pkg::DAYS_W-1:0]          days_elapsed,
	output logic signed [slrd_pkg::REM_W-1:0]    remaining_days
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_YEARS,
		ST_CHECK,
		ST_MONTHS,
		ST_DAYS,
		ST_EMIT,
		ST_REJECT
	} state_t;

	state_t state_q;

	logic [4:0]                  today_day_q;
	logic [3:0]                  today_month_q;
	logic [slrd_pkg::YEAR_W-1:0] today_year_q;

	logic [6:0]                  arr_day_q;
	logic [6:0]                  arr_month_q;
	logic [slrd_pkg::YEAR_W-1:0] arr_year_q;
	logic [15:0]                 shelf_q;
	logic [slrd_pkg::YEAR_W-1:0] cursor_q;
	logic [3:0]                  month_q;
	logic                        leap_arr_q;
	logic                        leap_today_q;

	logic                                done_q;
	logic                                ok_q;
	logic [slrd_pkg::DAYS_W-1:0]         days_q;
	logic signed [slrd_pkg::REM_W-1:0]   rem_q;

	slrd_pkg::acc_ctl_t                  acc_ctl;
	slrd_pkg::leap_ctl_t                 leap_ctl;
	logic                                leap_now;
	logic signed [slrd_pkg::ACC_W-1:0]   total;

	logic                        accept;
	logic                        year_bad;
	logic                        arr_real;
	logic                        today_real;
	logic                        order_bad;
	logic [4:0]                  len_today;
	logic [4:0]                  len_arr;
	logic [5:0]                  step_today;
	logic [5:0]                  step_arr;
	logic [slrd_pkg::DAYS_W-1:0] days_final;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// Hold today's date; writes beyond the register list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			today_day_q   <= 5'd1;
			today_month_q <= 4'd1;
			today_year_q  <= slrd_pkg::YEAR_W'(2000);
		end else if (wr_en) begin
			unique case (wr_index)
				slrd_pkg::REG_TODAY_DAY:   today_day_q   <= wr_data[4:0];
				slrd_pkg::REG_TODAY_MONTH: today_month_q <= wr_data[3:0];
				slrd_pkg::REG_TODAY_YEAR:  today_year_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// Reject out-of-range years and arrivals in a later year at once
	assign year_bad = (today_year_q > slrd_pkg::YEAR_W'(slrd_pkg::YEAR_LIMIT)) ||
			(arrival_year > slrd_pkg::YEAR_W'(slrd_pkg::YEAR_LIMIT)) ||
			(arrival_year > today_year_q);

	// Check both dates against their month lengths once leap flags are known
	assign arr_real = (arr_month_q >= 7'd1) && (arr_month_q <= 7'd12) &&
			(arr_day_q >= 7'd1) &&
			(arr_day_q <= {2'b00, slrd_pkg::month_len(arr_month_q[3:0], leap_arr_q)});
	assign today_real = (today_month_q >= 4'd1) && (today_month_q <= slrd_pkg::MONTH_DEC) &&
			(today_day_q >= 5'd1) &&
			(today_day_q <= slrd_pkg::month_len(today_month_q, leap_today_q));
	assign order_bad = (arr_year_q == today_year_q) &&
			((arr_month_q > {3'b000, today_month_q}) ||
			((arr_month_q == {3'b000, today_month_q}) &&
			(arr_day_q > {2'b00, today_day_q})));

	// Month step: days of this month before today minus those before arrival
	assign len_today  = slrd_pkg::month_len(month_q, leap_today_q);
	assign len_arr    = slrd_pkg::month_len(month_q, leap_arr_q);
	assign step_today = (month_q < today_month_q) ? {1'b0, len_today} : 6'd0;
	assign step_arr   = ({3'b000, month_q} < arr_month_q) ? {1'b0, len_arr} : 6'd0;

	// Drive the shared accumulator and the leap tracker
	always_comb begin
		acc_ctl.clear    = accept;
		acc_ctl.add      = 1'b0;
		acc_ctl.delta    = '0;
		leap_ctl.clear   = accept;
		leap_ctl.advance = 1'b0;
		case (state_q)
			ST_YEARS: begin
				if (cursor_q != today_year_q) begin
					leap_ctl.advance = 1'b1;
					if (cursor_q >= arr_year_q) begin
						acc_ctl.add   = 1'b1;
						acc_ctl.delta = leap_now ? slrd_pkg::DAYS_LEAP_YEAR :
								slrd_pkg::DAYS_PLAIN_YEAR;
					end
				end
			end
			ST_MONTHS: begin
				acc_ctl.add   = 1'b1;
				acc_ctl.delta = slrd_pkg::DELTA_W'(step_today) -
						slrd_pkg::DELTA_W'(step_arr);
			end
			ST_DAYS: begin
				acc_ctl.add   = 1'b1;
				acc_ctl.delta = slrd_pkg::DELTA_W'(today_day_q) -
						slrd_pkg::DELTA_W'(arr_day_q);
			end
			default: ;
		endcase
	end

	slrd_leap_track u_leap (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (leap_ctl),
		.leap   (leap_now)
	);

	slrd_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (acc_ctl),
		.total  (total)
	);

	// The walk never leaves a negative total for a date not after today
	assign days_final = total[slrd_pkg::DAYS_W-1:0];

	// Sequence one request and register the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			done_q       <= 1'b0;
			ok_q         <= 1'b0;
			days_q       <= '0;
			rem_q        <= '0;
			arr_day_q    <= '0;
			arr_month_q  <= '0;
			arr_year_q   <= '0;
			shelf_q      <= '0;
			cursor_q     <= '0;
			month_q      <= '0;
			leap_arr_q   <= 1'b0;
			leap_today_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						arr_day_q   <= arrival_day;
						arr_month_q <= arrival_month;
						arr_year_q  <= arrival_year;
						shelf_q     <= shelf_life;
						cursor_q    <= '0;
						state_q     <= year_bad ? ST_REJECT : ST_YEARS;
					end
				end
				ST_YEARS: begin
					if (cursor_q == arr_year_q) begin
						leap_arr_q <= leap_now;
					end
					if (cursor_q == today_year_q) begin
						leap_today_q <= leap_now;
						state_q      <= ST_CHECK;
					end else begin
						cursor_q <= cursor_q + 1'b1;
					end
				end
				ST_CHECK: begin
					month_q <= 4'd1;
					if (arr_real && today_real && !order_bad) begin
						state_q <= ST_MONTHS;
					end else begin
						state_q <= ST_REJECT;
					end
				end
				ST_MONTHS: begin
					if (month_q == slrd_pkg::MONTH_NOV) begin
						state_q <= ST_DAYS;
					end else begin
						month_q <= month_q + 4'd1;
					end
				end
				ST_DAYS: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					done_q  <= 1'b1;
					ok_q    <= 1'b1;
					days_q  <= days_final;
					rem_q   <= $signed({7'b0, shelf_q}) - $signed({1'b0, days_final});
					state_q <= ST_IDLE;
				end
				ST_REJECT: begin
					done_q  <= 1'b1;
					ok_q    <= 1'b0;
					days_q  <= '0;
					rem_q   <= '0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done           = done_q;
	assign date_ok        = ok_q;
	assign days_elapsed   = days_q;
	assign remaining_days = rem_q;

endmodule

// ===== rtl/slrd_checker.sv =====
// Port-level checker for the shelf life block, bound to the top level.
module slrd_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic                                done,
	input logic                                date_ok,
	input logic [slrd_pkg::DAYS_W-1:0]         days_elapsed,
	input logic signed [slrd_pkg::REM_W-1:0]   remaining_days
);

	// A result is shown only once the block has gone idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// A request that is taken keeps the block busy on the next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request taken without going busy");

	// Every result ends a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a request in progress");

	// A rejected date gives zero results
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !date_ok) |-> (days_elapsed == '0 && remaining_days == '0))
		else $error("rejected date with nonzero results");

endmodule

bind shelf_life_remaining_days slrd_checker u_slrd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.date_ok        (date_ok),
	.days_elapsed   (days_elapsed),
	.remaining_days (remaining_days)
);

// ===== test/shelf_life_checker.sv =====
// Checker for the shelf life block: tracks today's date, predicts every result and compares it.
`timescale 1ns / 100ps

module shelf_life_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [1:0]                         wr_index,
	input  logic [slrd_pkg::YEAR_W-1:0]        wr_data,
	input  logic                               start,
	input  logic                               busy,
	input  logic [6:0]                         arrival_day,
	input  logic [6:0]                         arrival_month,
	input  logic [slrd_pkg::YEAR_W-1:0]        arrival_year,
	input  logic [15:0]                        shelf_life,
	input  logic                               done,
	input  logic                               date_ok,
	input  logic [slrd_pkg::DAYS_W-1:0]        days_elapsed,
	input  logic signed [slrd_pkg::REM_W-1:0]  remaining_days,
	output int                                 fail_count,
	output int                                 requests_open
);
	import slrd_pkg::*;

	localparam longint DAYS_CAP = (longint'(1) << DAYS_W) - 1;

	typedef struct packed {
		logic                     ok;
		logic [DAYS_W-1:0]        elapsed;
		logic signed [REM_W-1:0]  remaining;
	} shelf_result_t;

	// today's date as last written over the register port
	logic [4:0]         today_day;
	logic [3:0]         today_month;
	logic [YEAR_W-1:0]  today_year;

	shelf_result_t      pending_results[$];
	shelf_result_t      want;
	shelf_result_t      got;
	int                 step_errors;

	function automatic bit leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
		if (m == MONTH_FEB)
			return leap_year(y) ? 29 : 28;
		if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
			return 30;
		return 31;
	endfunction

	function automatic bit real_date(input int unsigned d, input int unsigned m,
			input int unsigned y);
		return m >= 1 && m <= MONTH_DEC && d >= 1 && y <= YEAR_LIMIT && d <= month_days(m, y);
	endfunction

	// Days from the first day of year 0 up to and including the given date
	function automatic longint day_number(input int unsigned d, input int unsigned m,
			input int unsigned y);
		longint ly;
		longint n;
		ly = longint'(y);
		n = 365 * ly + (ly + 3) / 4 - (ly + 99) / 100 + (ly + 399) / 400;
		for (int unsigned k = 1; k < m; k++)
			n += month_days(k, y);
		return n + d;
	endfunction

	function automatic shelf_result_t predict_shelf(input logic [6:0] ad, input logic [6:0] am,
			input logic [YEAR_W-1:0] ay, input logic [15:0] shelf, input logic [4:0] td,
			input logic [3:0] tm, input logic [YEAR_W-1:0] ty);
		shelf_result_t r;
		longint span;
		r = '0;
		if (!real_date(ad, am, ay) || !real_date(td, tm, ty))
			return r;
		span = day_number(td, tm, ty) - day_number(ad, am, ay);
		// arrival after today
		if (span < 0)
			return r;
		if (span > DAYS_CAP)
			span = DAYS_CAP;
		r.ok = 1'b1;
		r.elapsed = span[DAYS_W-1:0];
		r.remaining = REM_W'(longint'(shelf) - span);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			today_day <= 5'd1;
			today_month <= 4'd1;
			today_year <= YEAR_W'(2000);
			pending_results.delete();
			fail_count <= 0;
			requests_open <= 0;
		end else begin
			step_errors = 0;
			// compare a finished request with the oldest prediction
			if (done) begin
				got = '{date_ok, days_elapsed, remaining_days};
				if (pending_results.size() == 0) begin
					$display("%0t: result with no request pending, date_ok %0d days_elapsed %0d",
						$time, got.ok, got.elapsed);
					step_errors++;
				end else begin
					want = pending_results.pop_front();
					if (got.ok !== want.ok) begin
						$display("%0t: date_ok expected %0d actual %0d", $time, want.ok, got.ok);
						step_errors++;
					end
					if (got.elapsed !== want.elapsed) begin
						$display("%0t: days_elapsed expected %0d actual %0d", $time,
							want.elapsed, got.elapsed);
						step_errors++;
					end
					if (got.remaining !== want.remaining) begin
						$display("%0t: remaining_days expected %0d actual %0d", $time,
							$signed(want.remaining), $signed(got.remaining));
						step_errors++;
					end
				end
			end
			// predict an accepted request against the current date
			if (start && !busy)
				pending_results.push_back(predict_shelf(arrival_day, arrival_month,
					arrival_year, shelf_life, today_day, today_month, today_year));
			// track register writes, drop unknown indexes
			if (wr_en) begin
				case (wr_index)
					REG_TODAY_DAY: today_day <= wr_data[4:0];
					REG_TODAY_MONTH: today_month <= wr_data[3:0];
					REG_TODAY_YEAR: today_year <= wr_data;
					default: ;
				endcase
			end
			fail_count <= fail_count + step_errors;
			requests_open <= pending_results.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the shelf life block: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb_top;
	import slrd_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 7;
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_REQUESTS = 10;
	localparam int TAIL_CYCLES = 20;
	localparam logic [1:0] REG_SPARE = 2'd3;

	logic                       clk;
	logic                       arst_n;
	logic                       wr_en;
	logic [1:0]                 wr_index;
	logic [YEAR_W-1:0]          wr_data;
	logic                       start;
	logic                       busy;
	logic [6:0]                 arrival_day;
	logic [6:0]                 arrival_month;
	logic [YEAR_W-1:0]          arrival_year;
	logic [15:0]                shelf_life;
	logic                       done;
	logic                       date_ok;
	logic [DAYS_W-1:0]          days_elapsed;
	logic signed [REM_W-1:0]    remaining_days;

	int                         fail_count;
	int                         requests_open;
	int                         quiet_cycles = 0;
	bit                         no_gaps = 1'b0;

	// today's date as written, after register masking
	int unsigned                now_day;
	int unsigned                now_month;
	int unsigned                now_year;

	shelf_life_remaining_days dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.start          (start),
		.busy           (busy),
		.arrival_day    (arrival_day),
		.arrival_month  (arrival_month),
		.arrival_year   (arrival_year),
		.shelf_life     (shelf_life),
		.done           (done),
		.date_ok        (date_ok),
		.days_elapsed   (days_elapsed),
		.remaining_days (remaining_days)
	);

	shelf_life_checker shelf_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.start          (start),
		.busy           (busy),
		.arrival_day    (arrival_day),
		.arrival_month  (arrival_month),
		.arrival_year   (arrival_year),
		.shelf_life     (shelf_life),
		.done           (done),
		.date_ok        (date_ok),
		.days_elapsed   (days_elapsed),
		.remaining_days (remaining_days),
		.fail_count     (fail_count),
		.requests_open  (requests_open)
	);

	always #HALF_PERIOD clk = ~clk;

	// End the run when neither a request nor a result moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
		bit leap;
		leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		if (m == MONTH_FEB)
			return leap ? 29 : 28;
		if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
			return 30;
		return 31;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [YEAR_W-1:0] data);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// Load today's date; upper data bits carry junk the registers must drop
	task automatic set_today(input logic [4:0] d, input logic [3:0] m,
			input logic [YEAR_W-1:0] y);
		write_reg(REG_SPARE, YEAR_W'($urandom));
		write_reg(REG_TODAY_DAY, {9'($urandom), d});
		write_reg(REG_TODAY_MONTH, {10'($urandom), m});
		write_reg(REG_TODAY_YEAR, y);
		now_day = d;
		now_month = m;
		now_year = y;
	endtask

	// Drop start and wait until every request has reported back
	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (requests_open != 0)
			@(posedge clk);
	endtask

	// Issue one request after a random gap and hold it until the block takes it
	task automatic send_request(input logic [6:0] d, input logic [6:0] m,
			input logic [YEAR_W-1:0] y, input logic [15:0] shelf);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		arrival_day <= d;
		arrival_month <= m;
		arrival_year <= y;
		shelf_life <= shelf;
		do @(posedge clk); while (busy);
	endtask

	// Pick a date for today: mostly real and early, sometimes impossible
	task automatic random_today;
		int unsigned d;
		int unsigned m;
		int unsigned y;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		y = (pick == 1) ? $urandom_range(0, 3) : $urandom_range(0, 450);
		m = $urandom_range(1, 12);
		case ($urandom_range(0, 2))
			0: d = 1;
			1: d = days_in_month(m, y);
			default: d = $urandom_range(1, days_in_month(m, y));
		endcase
		if (pick == 0) begin
			case ($urandom_range(0, 3))
				0: d = 0;
				1: m = $urandom_range(0, 1) ? 0 : $urandom_range(13, 15);
				2: d = days_in_month(m, y) + 1;
				default: y = $urandom_range(YEAR_LIMIT + 1, (1 << YEAR_W) - 1);
			endcase
		end
		set_today(5'(d), 4'(m), YEAR_W'(y));
	endtask

	// Mostly real arrival dates up to today, the rest broken dates and noise
	task automatic random_request;
		int unsigned d;
		int unsigned m;
		int unsigned y;
		int unsigned hi;
		int unsigned last_year;
		int unsigned kind;
		logic [15:0] shelf;
		kind = $urandom_range(0, 9);
		shelf = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 400)) : 16'($urandom);
		if (kind == 0) begin
			send_request(7'($urandom), 7'($urandom), YEAR_W'($urandom), shelf);
		end else begin
			last_year = (now_year > YEAR_LIMIT) ? YEAR_LIMIT : now_year;
			y = ($urandom_range(0, 3) == 0) ? last_year : $urandom_range(0, last_year);
			if (y == now_year && now_month >= 1 && now_month <= 12)
				m = $urandom_range(1, now_month);
			else
				m = $urandom_range(1, 12);
			hi = days_in_month(m, y);
			if (y == now_year && m == now_month && now_day >= 1 && now_day < hi)
				hi = now_day;
			d = ($urandom_range(0, 3) == 0) ? hi : $urandom_range(1, hi);
			// break the date: past the month end or after today
			if (kind == 1)
				d = days_in_month(m, y) + 1;
			else if (kind == 2)
				y = now_year + 1;
			send_request(7'(d), 7'(m), YEAR_W'(y), shelf);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_TODAY_DAY;
		wr_data = '0;
		start = 1'b0;
		arrival_day = '0;
		arrival_month = '0;
		arrival_year = '0;
		shelf_life = '0;
		now_day = 1;
		now_month = 1;
		now_year = 2000;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// today after reset is 2000-01-01
		send_request(7'd1, 7'd1, YEAR_W'(2000), 16'd0);
		send_request(7'd1, 7'd1, YEAR_W'(2000), 16'hFFFF);
		send_request(7'd31, 7'd12, YEAR_W'(1999), 16'd0);
		// century year without Feb 29, then ordinary and year-zero leap days
		send_request(7'd29, 7'd2, YEAR_W'(1900), 16'd100);
		send_request(7'd29, 7'd2, YEAR_W'(1896), 16'd100);
		send_request(7'd29, 7'd2, YEAR_W'(0), 16'd7);
		send_request(7'd1, 7'd1, YEAR_W'(0), 16'hFFFF);
		send_request(7'd31, 7'd8, YEAR_W'(1999), 16'd500);
		// bad day and month fields
		send_request(7'd0, 7'd6, YEAR_W'(1999), 16'd1);
		send_request(7'd1, 7'd0, YEAR_W'(1999), 16'd1);
		send_request(7'd1, 7'd13, YEAR_W'(1999), 16'd1);
		send_request(7'd32, 7'd1, YEAR_W'(1999), 16'd1);
		send_request(7'd31, 7'd4, YEAR_W'(1999), 16'd1);
		// arrival after today, year beyond the limit
		send_request(7'd2, 7'd1, YEAR_W'(2000), 16'd1);
		send_request(7'd1, 7'd1, YEAR_W'(2001), 16'd1);
		send_request(7'd1, 7'd1, YEAR_W'(10000), 16'd1);
		send_request(7'd127, 7'd127, YEAR_W'(16383), 16'hFFFF);
		drain();

		// latest possible today: longest walk
		set_today(5'd31, 4'd12, YEAR_W'(YEAR_LIMIT));
		send_request(7'd1, 7'd1, YEAR_W'(0), 16'd0);
		send_request(7'd31, 7'd12, YEAR_W'(YEAR_LIMIT), 16'hFFFF);
		send_request(7'd29, 7'd2, YEAR_W'(9996), 16'd3);
		send_request(7'd29, 7'd2, YEAR_W'(YEAR_LIMIT), 16'd3);
		drain();

		// today on the leap day of 2024, arrivals in the year before and on that day
		set_today(5'd29, 4'd2, YEAR_W'(2024));
		send_request(7'd1, 7'd3, YEAR_W'(2023), 16'd365);
		send_request(7'd29, 7'd2, YEAR_W'(2024), 16'd0);
		drain();

		// today is not a real date
		set_today(5'd29, 4'd2, YEAR_W'(2023));
		send_request(7'd1, 7'd1, YEAR_W'(2023), 16'd5);
		drain();

		// earliest possible today
		set_today(5'd1, 4'd1, YEAR_W'(0));
		send_request(7'd1, 7'd1, YEAR_W'(0), 16'd9);
		drain();

		// random phases, each under its own date
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			random_today();
			no_gaps = ($urandom_range(0, 2) == 0);
			for (int i = 0; i < PHASE_REQUESTS; i++)
				random_request();
			drain();
		end
		no_gaps = 1'b0;

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
